// ===== rtl/cdsc_pkg.sv =====
// package: word types, field step codes and register indexes of the clock setting controller
package cdsc_pkg;

	// input word: one 1 ms tick
	typedef struct packed {
		logic       key_a_level;
		logic       button_level;
		logic [4:0] rtc_hours;
		logic [5:0] rtc_minutes;
		logic [4:0] rtc_day;
		logic [3:0] rtc_month;
		logic [6:0] rtc_year;
		logic       rtc_century;
	} cdsc_in_t;

	// result word: display values and strobes
	typedef struct packed {
		logic [2:0] editing_field;
		logic       field_blank;
		logic [4:0] shown_hours;
		logic [5:0] shown_minutes;
		logic [4:0] shown_day;
		logic [3:0] shown_month;
		logic [6:0] shown_year;
		logic       shown_century;
		logic       refresh;
		logic       commit;
	} cdsc_out_t;

	// working copy of time and date
	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       century;
	} cdsc_td_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_REFRESH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_REFRESH = 3'd4;

	// field steps while setting
	localparam logic [2:0] STEP_HOURS   = 3'd0;
	localparam logic [2:0] STEP_MINUTES = 3'd1;
	localparam logic [2:0] STEP_DAY     = 3'd2;
	localparam logic [2:0] STEP_MONTH   = 3'd3;
	localparam logic [2:0] STEP_YEAR    = 3'd4;

	// register reset values
	localparam logic [15:0] LONG_PRESS_RST   = 16'd2000;
	localparam logic [15:0] BLINK_RST        = 16'd250;
	localparam logic [7:0]  HOLD_REPEAT_RST  = 8'd50;
	localparam logic [15:0] SLOW_REFRESH_RST = 16'd1000;
	localparam logic [15:0] FAST_REFRESH_RST = 16'd40;
	localparam logic [15:0] REFRESH_CNT_RST  = 16'd1000;

	// wrap limits
	localparam logic [7:0] HOURS_MOD   = 8'd24;
	localparam logic [7:0] MINUTES_MOD = 8'd60;
	localparam logic [7:0] DAY_LIMIT   = 8'd32;
	localparam logic [7:0] MONTH_LIMIT = 8'd13;
	localparam logic [7:0] YEAR_LIMIT  = 8'd100;

	// increment one field with its wrap; bit 7 flags a year wrap (century toggle)
	function automatic logic [7:0] bump_field(input logic [2:0] step, input logic [6:0] v);
		logic [7:0] n;
		logic [7:0] r;
		n = {1'b0, v} + 8'd1;
		case (step)
			STEP_HOURS:   r = (n >= HOURS_MOD) ? n - HOURS_MOD : n;
			STEP_MINUTES: r = (n >= MINUTES_MOD) ? n - MINUTES_MOD : n;
			STEP_DAY:     r = (n >= DAY_LIMIT) ? 8'd1 : n;
			STEP_MONTH:   r = (n >= MONTH_LIMIT) ? 8'd1 : n;
			default:      r = (n >= YEAR_LIMIT) ? 8'h80 : n;
		endcase
		return r;
	endfunction

	// 16-bit saturating increment
	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

// ===== rtl/clock_date_setting_controller_unit.sv =====
// Clock and date setting controller: one tick word in, one display word out.
//
// Usage: each input word is one 1 ms tick with the key A level, the button level
// (0 pressed) and the current clock time and date. Each accepted word yields exactly
// one result word: the field being edited, its blink state, the working time and
// date, a redraw strobe and a commit strobe (write the shown values, seconds zero).
// Channels: in_valid/in_stall and out_valid/out_stall; a word moves when valid is
// high and stall low. The configuration channel (cfg_valid/cfg_ready, always ready)
// writes the five timing registers by index; write only while idle.
// Latency: the result of a word is presented on the cycle after it is accepted.
// Throughput: one word per clock; all tick work is a single pass of compares,
// saturating counters and small wraps ahead of the output register.
// Stall: the output register holds its word while out_stall is high; a new word
// is still taken in the cycle the held one leaves, so in_stall only follows
// out_stall while a result is waiting.
// Reset: arst_n clears the control state, loads the register defaults and
// empties the output register; the first tick primes the previous key A level.
module clock_date_setting_controller_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  cdsc_pkg::cdsc_in_t       in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output cdsc_pkg::cdsc_out_t      out_data,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [cdsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cdsc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cdsc_pkg::*;

	// configuration registers
	logic [15:0] long_press_q, blink_ticks_q, slow_refresh_q, fast_refresh_q;
	logic [7:0]  hold_repeat_q;

	// tick state
	logic        setting_q, pending_loaded_q, blink_off_q, repeating_q;
	logic        next_request_q, force_refresh_q, key_a_prev_q, key_a_primed_q;
	logic        button_prev_q;
	logic [2:0]  field_step_q;
	logic [6:0]  pending_value_q;
	logic [7:0]  hold_count_q;
	logic [15:0] long_press_cnt_q, refresh_cnt_q, blink_cnt_q;
	cdsc_td_t    work_q;

	// output register
	logic        out_valid_q;
	cdsc_out_t   out_word_q;

	// next values
	logic        setting_n, pending_loaded_n, blink_off_n, repeating_n;
	logic        next_request_n, force_refresh_n, key_a_prev_n, button_prev_n;
	logic [2:0]  field_step_n;
	logic [6:0]  pending_value_n;
	logic [7:0]  hold_count_n;
	logic [15:0] long_press_cnt_n, refresh_cnt_n, blink_cnt_n;
	cdsc_td_t    work_n;
	cdsc_out_t   result;

	logic        accept;
	logic        key_a, btn, held, refresh_now, commit_now;
	logic [15:0] limit;
	logic [7:0]  bumped;

	assign accept    = in_valid & ~in_stall;
	assign in_stall  = out_valid_q & out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;
	assign cfg_ready = 1'b1;

	// one tick of the setting controller
	always_comb begin
		key_a = in_data.key_a_level;
		btn   = in_data.button_level;

		setting_n        = setting_q;
		pending_loaded_n = pending_loaded_q;
		blink_off_n      = blink_off_q;
		repeating_n      = repeating_q;
		next_request_n   = next_request_q;
		force_refresh_n  = force_refresh_q;
		key_a_prev_n     = key_a_primed_q ? key_a_prev_q : key_a;
		field_step_n     = field_step_q;
		pending_value_n  = pending_value_q;
		hold_count_n     = hold_count_q;
		long_press_cnt_n = long_press_cnt_q;
		refresh_cnt_n    = refresh_cnt_q;
		blink_cnt_n      = blink_cnt_q;
		work_n           = work_q;
		commit_now       = 1'b0;
		held             = 1'b0;
		bumped           = 8'd0;

		// working copy follows the clock while idle
		if (!setting_q) begin
			work_n.hours   = in_data.rtc_hours;
			work_n.minutes = in_data.rtc_minutes;
			work_n.day     = in_data.rtc_day;
			work_n.month   = in_data.rtc_month;
			work_n.year    = in_data.rtc_year;
			work_n.century = in_data.rtc_century;
		end

		// display refresh timer
		limit       = (setting_q && !btn) ? fast_refresh_q : slow_refresh_q;
		refresh_now = (refresh_cnt_q >= limit) || force_refresh_q;
		if (refresh_now) begin
			force_refresh_n = 1'b0;
			refresh_cnt_n   = 16'd0;
		end

		// key A: long press while idle, next field while setting
		if (key_a != key_a_prev_n) begin
			if (!setting_q) long_press_cnt_n = sat_inc16(long_press_cnt_q);
			else next_request_n = 1'b1;
		end else if (!setting_q) begin
			long_press_cnt_n = 16'd0;
		end

		// blink toggle
		if (blink_cnt_q >= blink_ticks_q) begin
			blink_off_n     = ~blink_off_q;
			blink_cnt_n     = 16'd0;
			force_refresh_n = 1'b1;
		end

		// field editing
		if (long_press_cnt_n >= long_press_q || setting_q) begin
			key_a_prev_n = key_a;
			setting_n    = 1'b1;
			if (field_step_q <= STEP_YEAR) begin
				held = hold_count_q >= hold_repeat_q;
				if (!pending_loaded_q) begin
					case (field_step_q)
						STEP_HOURS:   pending_value_n = {2'b0, work_n.hours};
						STEP_MINUTES: pending_value_n = {1'b0, work_n.minutes};
						STEP_DAY:     pending_value_n = {2'b0, work_n.day};
						STEP_MONTH:   pending_value_n = {3'b0, work_n.month};
						default:      pending_value_n = work_n.year;
					endcase
					pending_loaded_n = 1'b1;
				end
				if ((btn && !button_prev_q) || held) begin
					if (!blink_off_n) begin
						blink_cnt_n     = 16'd0;
						force_refresh_n = 1'b1;
					end
					bumped          = bump_field(field_step_q, pending_value_n);
					pending_value_n = bumped[6:0];
					if (bumped[7]) work_n.century = ~work_n.century;
					if (held) repeating_n = 1'b1;
					hold_count_n = 8'd0;
				end
				case (field_step_q)
					STEP_HOURS:   work_n.hours   = pending_value_n[4:0];
					STEP_MINUTES: work_n.minutes = pending_value_n[5:0];
					STEP_DAY:     work_n.day     = pending_value_n[4:0];
					STEP_MONTH:   work_n.month   = pending_value_n[3:0];
					default:      work_n.year    = pending_value_n;
				endcase
				if (next_request_n && !blink_off_n) begin
					next_request_n   = 1'b0;
					pending_loaded_n = 1'b0;
					field_step_n     = field_step_q + 3'd1;
				end
			end else begin
				commit_now   = 1'b1;
				field_step_n = STEP_HOURS;
				setting_n    = 1'b0;
			end
		end

		// button hold and blink timing
		button_prev_n = btn;
		if (setting_n) begin
			if (btn) begin
				blink_cnt_n  = sat_inc16(blink_cnt_n);
				repeating_n  = 1'b0;
				hold_count_n = 8'd0;
			end else begin
				if (repeating_n) button_prev_n = 1'b1;
				blink_off_n = 1'b0;
				if (hold_count_n != 8'hFF) hold_count_n = hold_count_n + 8'd1;
			end
		end
		refresh_cnt_n = sat_inc16(refresh_cnt_n);

		// result word
		result.editing_field = setting_n ? field_step_n + 3'd1 : 3'd0;
		result.field_blank   = setting_n & blink_off_n;
		result.shown_hours   = work_n.hours;
		result.shown_minutes = work_n.minutes;
		result.shown_day     = work_n.day;
		result.shown_month   = work_n.month;
		result.shown_year    = work_n.year;
		result.shown_century = work_n.century;
		result.refresh       = refresh_now;
		result.commit        = commit_now;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= LONG_PRESS_RST;
			blink_ticks_q  <= BLINK_RST;
			hold_repeat_q  <= HOLD_REPEAT_RST;
			slow_refresh_q <= SLOW_REFRESH_RST;
			fast_refresh_q <= FAST_REFRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LONG_PRESS:   long_press_q   <= cfg_data;
				REG_BLINK:        blink_ticks_q  <= cfg_data;
				REG_HOLD_REPEAT:  hold_repeat_q  <= cfg_data[7:0];
				REG_SLOW_REFRESH: slow_refresh_q <= cfg_data;
				REG_FAST_REFRESH: fast_refresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setting_q        <= 1'b0;
			pending_loaded_q <= 1'b0;
			blink_off_q      <= 1'b0;
			repeating_q      <= 1'b0;
			next_request_q   <= 1'b0;
			force_refresh_q  <= 1'b0;
			key_a_prev_q     <= 1'b0;
			key_a_primed_q   <= 1'b0;
			button_prev_q    <= 1'b1;
			field_step_q     <= STEP_HOURS;
			pending_value_q  <= 7'd0;
			hold_count_q     <= 8'd0;
			long_press_cnt_q <= 16'd0;
			refresh_cnt_q    <= REFRESH_CNT_RST;
			blink_cnt_q      <= 16'd0;
			work_q           <= '0;
		end else if (accept) begin
			setting_q        <= setting_n;
			pending_loaded_q <= pending_loaded_n;
			blink_off_q      <= blink_off_n;
			repeating_q      <= repeating_n;
			next_request_q   <= next_request_n;
			force_refresh_q  <= force_refresh_n;
			key_a_prev_q     <= key_a_prev_n;
			key_a_primed_q   <= 1'b1;
			button_prev_q    <= button_prev_n;
			field_step_q     <= field_step_n;
			pending_value_q  <= pending_value_n;
			hold_count_q     <= hold_count_n;
			long_press_cnt_q <= long_press_cnt_n;
			refresh_cnt_q    <= refresh_cnt_n;
			blink_cnt_q      <= blink_cnt_n;
			work_q           <= work_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q <= result;
		end
	end

endmodule
